[design/assert_macros.svh]
// assertion helpers for the design files, used by sidht_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define SIDHT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sidht check failed");
// checked on every edge, reset included
`define SIDHT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sidht check failed");
`else
`define SIDHT_ASSERT(lbl, prop)
`define SIDHT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/sidht_pkg.sv]
package sidht_pkg;

	localparam int unsigned CAPACITY_DEF    = 256;
	localparam int unsigned HANDLE_BITS_DEF = 32;
	localparam int unsigned ID_W            = 16;
	localparam int unsigned HANDLE_W        = 32;
	localparam int unsigned POS_W           = 8;
	localparam int unsigned ST_W            = 3;

	typedef enum logic [ST_W-1:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REFILLED = 3'd2,
		ST_FAILED   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOKUP,
		S_SEARCH,
		S_SEARCH_CMP,
		S_CHECK,
		S_MISS,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    rd_direct;
		logic    rd_mid;
		logic    step;
		logic    rd_shift;
		logic    wr_shift;
		logic    wr_refill;
		logic    wr_insert;
		logic    rd_dense;
		logic    dense_inc;
		logic    emit;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic direct;
		logic search_open;
		logic key_eq;
		logic key_lt;
		logic stored_zero;
		logic new_zero;
		logic full;
		logic shift_more;
		logic dense_more;
		logic dense_match;
		logic out_free;
	} sts_t;

endpackage

[design/sidht_in_if.sv]
interface sidht_in_if;
	logic                            valid;
	logic                            ready;
	logic [sidht_pkg::ID_W-1:0]      key_id;
	logic [sidht_pkg::HANDLE_W-1:0]  new_handle;

	modport source(output valid, key_id, new_handle, input ready);
	modport sink(input valid, key_id, new_handle, output ready);
endinterface

[design/sidht_out_if.sv]
interface sidht_out_if;
	logic                            valid;
	logic                            ready;
	logic [sidht_pkg::ST_W-1:0]      status;
	logic [sidht_pkg::HANDLE_W-1:0]  handle;
	logic [sidht_pkg::POS_W-1:0]     position;

	modport source(output valid, status, handle, position, input ready);
	modport sink(input valid, status, handle, position, output ready);
endinterface

[design/sorted_id_handle_table_top.sv]
// get-or-add table from a 16-bit id to a handle, kept sorted by id in one ram
// req channel: key_id and new_handle, one transfer per lookup
// rsp channel: status, handle and position, exactly one transfer per request
// req.ready is high only while no request is in progress, one request at a time
// a lookup inside the dense run (id equals slot) takes one ram read; others
// take a binary search of about log2(entries) probes
// an insert moves every entry from the new slot upward up one, top first, writes
// the new entry, then grows the dense run slot by slot until an id does not
// match its slot or the run reaches the entry count
// the ram has one write and one read port
// reset clears the entry count, the dense run and the response valid flag; the
// table is empty afterwards and no clearing pass is needed
// a stalled rsp holds its result; the next request is taken meanwhile and
// waits at its final step until the result register is free
module sorted_id_handle_table_top #(
	parameter int unsigned CAPACITY    = sidht_pkg::CAPACITY_DEF,
	parameter int unsigned HANDLE_BITS = sidht_pkg::HANDLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sidht_in_if.sink    req,
	sidht_out_if.source rsp
);

	sidht_pkg::cmd_t cmd;
	sidht_pkg::sts_t sts;

	sidht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sidht_dp #(
		.CAPACITY   (CAPACITY),
		.HANDLE_BITS(HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_id    (req.key_id),
		.new_handle(req.new_handle),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

[design/sidht_ram.sv]
module sidht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/sidht_ctrl.sv]
module sidht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sidht_pkg::sts_t   sts,
	output sidht_pkg::cmd_t   cmd
);

	sidht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.code  = sidht_pkg::ST_HIT;
		req_ready = 1'b0;
		unique case (state_q)
			sidht_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = sidht_pkg::S_LOOKUP;
				end
			end
			sidht_pkg::S_LOOKUP: begin
				// ids inside the dense run sit at their own slot
				if (sts.direct) begin
					cmd.rd_direct = 1'b1;
					state_d       = sidht_pkg::S_CHECK;
				end else begin
					state_d = sidht_pkg::S_SEARCH;
				end
			end
			sidht_pkg::S_SEARCH: begin
				if (sts.search_open) begin
					cmd.rd_mid = 1'b1;
					state_d    = sidht_pkg::S_SEARCH_CMP;
				end else begin
					state_d = sidht_pkg::S_MISS;
				end
			end
			sidht_pkg::S_SEARCH_CMP: begin
				if (sts.key_eq) begin
					state_d = sidht_pkg::S_CHECK;
				end else begin
					cmd.step = 1'b1;
					state_d  = sidht_pkg::S_SEARCH;
				end
			end
			sidht_pkg::S_CHECK: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sidht_pkg::S_IDLE;
					priority if (!sts.stored_zero) begin
						cmd.code = sidht_pkg::ST_HIT;
					end else if (sts.new_zero) begin
						cmd.code = sidht_pkg::ST_FAILED;
					end else begin
						cmd.code      = sidht_pkg::ST_REFILLED;
						cmd.wr_refill = 1'b1;
					end
				end
			end
			sidht_pkg::S_MISS: begin
				priority if (sts.full) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.code = sidht_pkg::ST_FULL;
						state_d  = sidht_pkg::S_IDLE;
					end
				end else if (sts.new_zero) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.code = sidht_pkg::ST_FAILED;
						state_d  = sidht_pkg::S_IDLE;
					end
				end else begin
					state_d = sidht_pkg::S_SH_RD;
				end
			end
			sidht_pkg::S_SH_RD: begin
				// move entries up one slot, top first
				if (sts.shift_more) begin
					cmd.rd_shift = 1'b1;
					state_d      = sidht_pkg::S_SH_WR;
				end else begin
					state_d = sidht_pkg::S_INS_WR;
				end
			end
			sidht_pkg::S_SH_WR: begin
				cmd.wr_shift = 1'b1;
				state_d      = sidht_pkg::S_SH_RD;
			end
			sidht_pkg::S_INS_WR: begin
				cmd.wr_insert = 1'b1;
				state_d       = sidht_pkg::S_DN_RD;
			end
			sidht_pkg::S_DN_RD: begin
				if (sts.dense_more) begin
					cmd.rd_dense = 1'b1;
					state_d      = sidht_pkg::S_DN_CMP;
				end else begin
					state_d = sidht_pkg::S_FIN;
				end
			end
			sidht_pkg::S_DN_CMP: begin
				if (sts.dense_match) begin
					cmd.dense_inc = 1'b1;
					state_d       = sidht_pkg::S_DN_RD;
				end else begin
					state_d = sidht_pkg::S_FIN;
				end
			end
			sidht_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.code = sidht_pkg::ST_INSERTED;
					state_d  = sidht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sidht_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[design/sidht_dp.sv]
`include "assert_macros.svh"

module sidht_dp #(
	parameter int unsigned CAPACITY    = sidht_pkg::CAPACITY_DEF,
	parameter int unsigned HANDLE_BITS = sidht_pkg::HANDLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sidht_pkg::ID_W-1:0]     key_id,
	input  logic [sidht_pkg::HANDLE_W-1:0] new_handle,
	input  sidht_pkg::cmd_t                cmd,
	output sidht_pkg::sts_t                sts,
	sidht_out_if.source                    rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = sidht_pkg::ID_W + HANDLE_BITS;

	logic [sidht_pkg::ID_W-1:0]     key_q;
	logic [HANDLE_BITS-1:0]         hnd_q;
	logic [CW-1:0]                  lo_q;
	logic [CW-1:0]                  hi_q;
	logic [CW-1:0]                  ptr_q;
	logic [AW-1:0]                  found_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  dense_q;
	logic                           out_valid_q;
	logic [sidht_pkg::ST_W-1:0]     status_q;
	logic [sidht_pkg::HANDLE_W-1:0] handle_q;
	logic [sidht_pkg::POS_W-1:0]    position_q;

	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [EW-1:0]                  wr_data;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic [EW-1:0]                  rd_data;
	logic [sidht_pkg::ID_W-1:0]     rd_id;
	logic [HANDLE_BITS-1:0]         rd_hnd;
	logic [CW:0]                    mid_sum;
	logic [AW-1:0]                  mid;
	logic [sidht_pkg::HANDLE_W-1:0] emit_handle;
	logic [sidht_pkg::POS_W-1:0]    emit_pos;

	sidht_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_id   = rd_data[EW-1 -: sidht_pkg::ID_W];
	assign rd_hnd  = rd_data[HANDLE_BITS-1:0];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = AW'(mid_sum >> 1);

	always_comb begin
		sts.direct      = key_q < sidht_pkg::ID_W'(dense_q);
		sts.search_open = lo_q < hi_q;
		sts.key_eq      = key_q == rd_id;
		sts.key_lt      = key_q < rd_id;
		sts.stored_zero = rd_hnd == '0;
		sts.new_zero    = hnd_q == '0;
		sts.full        = count_q >= CW'(CAPACITY);
		sts.shift_more  = ptr_q > lo_q;
		sts.dense_more  = dense_q < count_q;
		sts.dense_match = rd_id == sidht_pkg::ID_W'(dense_q);
		sts.out_free    = !out_valid_q || rsp.ready;
	end

	// memory port selection
	always_comb begin
		rd_en = cmd.rd_direct | cmd.rd_mid | cmd.rd_shift | cmd.rd_dense;
		priority if (cmd.rd_direct) begin
			rd_addr = AW'(key_q);
		end else if (cmd.rd_mid) begin
			rd_addr = mid;
		end else if (cmd.rd_shift) begin
			rd_addr = AW'(ptr_q - CW'(1));
		end else begin
			rd_addr = AW'(dense_q);
		end

		wr_en = cmd.wr_shift | cmd.wr_refill | cmd.wr_insert;
		priority if (cmd.wr_shift) begin
			wr_addr = AW'(ptr_q);
			wr_data = rd_data;
		end else if (cmd.wr_refill) begin
			wr_addr = found_q;
			wr_data = {key_q, hnd_q};
		end else begin
			wr_addr = AW'(lo_q);
			wr_data = {key_q, hnd_q};
		end
	end

	always_comb begin
		unique case (cmd.code)
			sidht_pkg::ST_HIT: begin
				emit_handle = sidht_pkg::HANDLE_W'(rd_hnd);
				emit_pos    = sidht_pkg::POS_W'(found_q);
			end
			sidht_pkg::ST_INSERTED: begin
				emit_handle = sidht_pkg::HANDLE_W'(hnd_q);
				emit_pos    = sidht_pkg::POS_W'(lo_q);
			end
			sidht_pkg::ST_REFILLED: begin
				emit_handle = sidht_pkg::HANDLE_W'(hnd_q);
				emit_pos    = sidht_pkg::POS_W'(found_q);
			end
			default: begin
				emit_handle = '0;
				emit_pos    = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dense_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_insert) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.dense_inc) begin
				dense_q <= dense_q + CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_q <= key_id;
			hnd_q <= HANDLE_BITS'(new_handle);
			lo_q  <= dense_q;
			hi_q  <= count_q;
			ptr_q <= count_q;
		end
		if (cmd.rd_direct) begin
			found_q <= AW'(key_q);
		end else if (cmd.rd_mid) begin
			found_q <= mid;
		end
		if (cmd.step) begin
			if (sts.key_lt) begin
				hi_q <= CW'(mid);
			end else begin
				lo_q <= CW'(mid) + CW'(1);
			end
		end
		if (cmd.wr_shift) begin
			ptr_q <= ptr_q - CW'(1);
		end
		if (cmd.emit) begin
			status_q   <= cmd.code;
			handle_q   <= emit_handle;
			position_q <= emit_pos;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.handle   = handle_q;
	assign rsp.position = position_q;

	`SIDHT_ASSERT(a_dense_in_table, dense_q <= count_q)
	`SIDHT_ASSERT(a_count_in_range, count_q <= CW'(CAPACITY))
	`SIDHT_ASSERT(a_emit_when_free, cmd.emit |-> (!out_valid_q || rsp.ready))
	`SIDHT_ASSERT(a_insert_has_room, cmd.wr_insert |-> (count_q < CW'(CAPACITY)))
	`SIDHT_ASSERT(a_shift_above_slot, cmd.wr_shift |-> (ptr_q > lo_q))

endmodule

[tb/sidht_table_checker.sv]
// watches both channels, predicts every lookup and compares the responses in order
module sidht_table_checker (
	input  logic  clk,
	input  logic  arst_n,
	sidht_in_if   req,
	sidht_out_if  rsp,
	output int    mismatches,
	output int    outstanding
);

	localparam int unsigned SLOTS = sidht_pkg::CAPACITY_DEF;
	localparam logic [sidht_pkg::HANDLE_W-1:0] HMASK =
		(sidht_pkg::HANDLE_BITS_DEF >= sidht_pkg::HANDLE_W) ? '1 :
		((sidht_pkg::HANDLE_W'(1) << sidht_pkg::HANDLE_BITS_DEF) - 1);

	typedef struct packed {
		sidht_pkg::status_t                code;
		logic [sidht_pkg::HANDLE_W-1:0]    hdl;
		logic [sidht_pkg::POS_W-1:0]       pos;
	} lookup_t;

	logic [sidht_pkg::ID_W-1:0]     slot_ids [SLOTS];
	logic [sidht_pkg::HANDLE_W-1:0] slot_handles [SLOTS];
	int                             fill;
	int                             dense_len;
	lookup_t                        pending_lookups [$];
	lookup_t                        oldest;

	// get-or-add on the mirrored table, returns the response the block must give
	function automatic lookup_t lookup_or_add(logic [sidht_pkg::ID_W-1:0] key,
			logic [sidht_pkg::HANDLE_W-1:0] offered);
		lookup_t r;
		int      lo;
		int      hi;
		int      mid;
		int      slot;
		bit      found;
		r.code = sidht_pkg::ST_FAILED;
		r.hdl  = '0;
		r.pos  = '0;
		offered = offered & HMASK;
		found = 1'b0;
		slot = 0;
		if (int'(key) < dense_len) begin
			found = 1'b1;
			slot = int'(key);
		end else begin
			lo = dense_len;
			hi = fill;
			while (lo < hi && !found) begin
				mid = (lo + hi) >> 1;
				if (key < slot_ids[mid])
					hi = mid;
				else if (key > slot_ids[mid])
					lo = mid + 1;
				else begin
					found = 1'b1;
					slot = mid;
				end
			end
			if (!found)
				slot = lo;
		end
		if (found) begin
			if (slot_handles[slot] != '0) begin
				r.code = sidht_pkg::ST_HIT;
				r.hdl  = slot_handles[slot];
				r.pos  = slot[sidht_pkg::POS_W-1:0];
			end else if (offered != '0) begin
				slot_handles[slot] = offered;
				r.code = sidht_pkg::ST_REFILLED;
				r.hdl  = offered;
				r.pos  = slot[sidht_pkg::POS_W-1:0];
			end
		end else if (fill >= SLOTS) begin
			r.code = sidht_pkg::ST_FULL;
		end else if (offered != '0) begin
			for (int i = fill; i > slot; i--) begin
				slot_ids[i]     = slot_ids[i-1];
				slot_handles[i] = slot_handles[i-1];
			end
			slot_ids[slot]     = key;
			slot_handles[slot] = offered;
			fill++;
			// the dense run only grows once the new entry sits in its slot
			while (dense_len < fill && int'(slot_ids[dense_len]) == dense_len)
				dense_len++;
			r.code = sidht_pkg::ST_INSERTED;
			r.hdl  = offered;
			r.pos  = slot[sidht_pkg::POS_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill        <= 0;
			dense_len   <= 0;
			mismatches  <= 0;
			outstanding <= 0;
			pending_lookups.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_lookups.size() == 0) begin
					if (mismatches < 10)
						$display("response with no lookup pending: st %0d h %h pos %0d",
							rsp.status, rsp.handle, rsp.position);
					mismatches <= mismatches + 1;
				end else begin
					oldest = pending_lookups.pop_front();
					if (rsp.status !== oldest.code || rsp.handle !== oldest.hdl ||
							rsp.position !== oldest.pos) begin
						if (mismatches < 10)
							$display({"lookup mismatch: exp st %0d h %h pos %0d, ",
								"got st %0d h %h pos %0d"},
								oldest.code, oldest.hdl, oldest.pos,
								rsp.status, rsp.handle, rsp.position);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req.valid && req.ready)
				pending_lookups.push_back(lookup_or_add(req.key_id, req.new_handle));
			outstanding <= pending_lookups.size();
		end
	end

endmodule

[tb/tb_sorted_id_handle_table_top.sv]
module tb_sorted_id_handle_table_top;

	localparam int RANDOM_LOOKUPS = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm;
	int   mismatches;
	int   outstanding;
	logic [sidht_pkg::ID_W-1:0] known_ids [$];

	sidht_in_if  req_if ();
	sidht_out_if rsp_if ();

	sorted_id_handle_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	sidht_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#150_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// one request transfer; valid stays high across back-to-back items
	task automatic offer_lookup(logic [sidht_pkg::ID_W-1:0] key,
			logic [sidht_pkg::HANDLE_W-1:0] hdl);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.key_id     <= key;
		req_if.new_handle <= hdl;
		do @(posedge clk); while (!req_if.ready);
		if (hdl != '0)
			known_ids.push_back(key);
	endtask

	// response side may stall before each transfer, never while calm
	initial begin
		int stall;
		rsp_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	initial begin
		int                             pick;
		logic [sidht_pkg::ID_W-1:0]     key;
		logic [sidht_pkg::HANDLE_W-1:0] hdl;
		req_if.valid      <= 1'b0;
		req_if.key_id     <= '0;
		req_if.new_handle <= '0;
		calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-order start of the dense run, then the gap filled
		offer_lookup(16'd2, 32'h0000_0022);
		offer_lookup(16'd1, 32'h0000_0011);
		offer_lookup(16'd0, 32'h0000_0000);
		offer_lookup(16'd0, 32'hA5A5_0000);
		offer_lookup(16'd1, 32'h0000_0000);
		offer_lookup(16'd2, 32'hFFFF_FFFF);
		offer_lookup(16'hFFFF, 32'hFFFF_FFFF);
		offer_lookup(16'hFFFF, 32'h0000_0000);
		offer_lookup(16'h8000, 32'h0000_0001);
		offer_lookup(16'd4, 32'h0000_0044);
		offer_lookup(16'd3, 32'h0000_0033);
		offer_lookup(16'h7FFF, 32'h8000_0000);
		offer_lookup(16'd4, 32'h0000_0000);
		offer_lookup(16'd5, 32'h0000_0000);
		offer_lookup(16'h0100, 32'h5555_5555);
		offer_lookup(16'hFFFE, 32'hAAAA_AAAA);
		offer_lookup(16'h8000, 32'h1234_5678);
		offer_lookup(16'd0, 32'h0000_0000);

		// random part fills the table, after which new ids report full
		for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				key = sidht_pkg::ID_W'($urandom_range(0, 47));
			else if (pick < 60)
				key = known_ids[$urandom_range(0, known_ids.size() - 1)];
			else if (pick < 75)
				key = sidht_pkg::ID_W'($urandom_range(16'hFF00, 16'hFFFF));
			else
				key = sidht_pkg::ID_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				hdl = '0;
			else if (pick < 13)
				hdl = '1;
			else
				hdl = $urandom;
			offer_lookup(key, hdl);
		end
		req_if.valid <= 1'b0;

		// let the count of the last transfer settle before waiting on it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
